/* rtl/core/pcg_pkg.sv */
// ----------------------------------------------------------------------------
// pcg_pkg
// constants and types shared by the color grade modules
// ----------------------------------------------------------------------------
`default_nettype none
package pcg_pkg;
   localparam int FracBits   = 12;
   localparam int TableDepth = 1024;
   localparam int IdxW       = $clog2(TableDepth);
   localparam int GammaW     = 13;
   localparam int GammaOne   = 4096;
   localparam int LumaR      = 19595;
   localparam int LumaG      = 38470;
   localparam int LumaB      = 7471;

   localparam logic [2:0] CsrBrightness = 3'd0;
   localparam logic [2:0] CsrContrast   = 3'd1;
   localparam logic [2:0] CsrSaturation = 3'd2;
   localparam logic [2:0] CsrTintRed    = 3'd3;
   localparam logic [2:0] CsrTintGreen  = 3'd4;
   localparam logic [2:0] CsrTintBlue   = 3'd5;

   // front to back queue entry
   typedef struct packed {
      logic                 write;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
      logic [7:0]           alpha;
      logic [9:0]           index;
      logic [GammaW-1:0]    value;
   } item_type;

   typedef struct packed {
      logic signed [9:0] brightness;
      logic [9:0]        contrast;
      logic [9:0]        saturation;
      logic [7:0]        tint_red;
      logic [7:0]        tint_green;
      logic [7:0]        tint_blue;
   } csr_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;
endpackage
`default_nettype wire

/* rtl/core/pcg_ram.sv */
// ----------------------------------------------------------------------------
// pcg_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module pcg_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/pcg_queue.sv */
// ----------------------------------------------------------------------------
// pcg_queue
// short fifo of item entries between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
module pcg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire pcg_pkg::item_type  push_data,
   output logic                    full,
   input  wire logic               pop,
   output pcg_pkg::item_type       pop_data,
   output logic                    empty
);
   import pcg_pkg::*;
   item_type   slot_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = cnt_ff == 3'd4;
   assign empty    = cnt_ff == 3'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'd0, do_push} - {2'd0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (do_push) slot_ff[wp_ff] <= push_data;
   end
endmodule
`default_nettype wire

/* rtl/core/pcg_back.sv */
// ----------------------------------------------------------------------------
// pcg_back
// grading pipeline: adjust, luma, blend, gamma lookup, tint, output fifo
// ----------------------------------------------------------------------------
`default_nettype none
module pcg_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcg_pkg::csr_type  csr,
   input  wire logic              in_valid,
   input  wire pcg_pkg::item_type in_item,
   output logic                   in_pop,
   output pcg_pkg::pixel_type     out_pixel,
   output logic                   out_empty,
   input  wire logic              out_pop
);
   import pcg_pkg::*;
   localparam int Stages = 7;   // valid stages ahead of the output fifo
   localparam int OutDepth = 8;
   localparam logic [FracBits:0] One = (FracBits+1)'(1 << FracBits);
   localparam logic signed [23:0] Half = 24'sd2048;

   // ---- pipeline control: all stages move together on advance
   logic [Stages-1:0] v_ff, v_in;
   logic [3:0]        ocnt_ff;
   logic [3:0]        inflight;
   logic              advance;

   always_comb begin
      inflight = '0;
      for (int i = 0; i < Stages; i++) inflight = inflight + {3'd0, v_ff[i]};
   end
   // stall only when the fifo could overflow with what is in flight; the item
   // leaving stage 7 is counted in the in-flight sum, so the sum may reach the fifo depth
   assign advance = ({1'b0, ocnt_ff} + {1'b0, inflight}) <= 5'(OutDepth);
   assign in_pop  = advance && in_valid;

   // ---- stage 1: table write or channel to fraction
   logic             s1w_ff;
   logic [9:0]       s1i_ff;
   logic [GammaW-1:0] s1val_ff;
   logic [12:0]      s1x_ff [3];
   logic [7:0]       s1a_ff;
   function automatic logic [12:0] to_frac(input logic [7:0] c);
      logic [42:0] t;
      t = 43'({c, 12'd0}) + 43'd127;
      return 13'((t * 43'd2105377) >> 29); // exact /255 over this range
   endfunction

   // ---- stage 2: brightness and contrast product
   logic signed [25:0] s2p_ff [3];
   logic [7:0]         s2a_ff;
   // ---- stage 3: adjusted channels
   logic signed [23:0] s3x_ff [3];
   logic [7:0]         s3a_ff;
   // ---- stage 4: luma products summed
   logic signed [42:0] s4l_ff;
   logic signed [23:0] s4x_ff [3];
   logic [7:0]         s4a_ff;
   // ---- stage 5: blend product
   logic signed [23:0] s5l_ff;
   logic signed [34:0] s5p_ff [3];
   logic [7:0]         s5a_ff;
   // ---- stage 6: index, ram read issued
   logic [7:0]         s6a_ff;
   // ---- stage 7: ram data, tint
   logic [7:0]         s7a_ff;

   // table writes travel to stage 5 so they meet the reads in item order
   logic [5:0]         wpipe_ff;     // write flag, stages 2 to 7
   logic [IdxW-1:0]    tidx_ff [4];  // write index, stages 2 to 5
   logic [GammaW-1:0]  tval_ff [4];  // write value, stages 2 to 5

   logic [IdxW-1:0]    idx [3];
   logic [GammaW-1:0]  gdat [3];
   logic [7:0]         tint [3];
   logic               ram_we;

   assign tint[0] = csr.tint_red;
   assign tint[1] = csr.tint_green;
   assign tint[2] = csr.tint_blue;
   assign ram_we  = advance && wpipe_ff[3] && v_ff[4];

   function automatic logic [IdxW-1:0] make_index(input logic signed [34:0] p,
                                                  input logic signed [23:0] l);
      logic signed [35:0] r;
      logic signed [35:0] v;
      logic [FracBits:0]  c;
      logic [25:0]        m;
      r = (36'(p) + 36'sd128) >>> 8;
      v = 36'(l) + r;
      if (v < 0) c = '0;
      else if (v > 36'(One)) c = One;
      else c = v[FracBits:0];
      m = 26'(c) * 26'(TableDepth - 1) + 26'(One >> 1);
      m = m >> FracBits;
      if (m >= 26'(TableDepth)) m = 26'(TableDepth - 1);
      return m[IdxW-1:0];
   endfunction

   for (genvar ch = 0; ch < 3; ch++) begin : g_ram
      assign idx[ch] = make_index(s5p_ff[ch], s5l_ff);
      pcg_ram #(.Width(GammaW), .Depth(TableDepth)) u_ram (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (tidx_ff[3]),
         .wr_data (tval_ff[3]),
         .rd_en   (advance),
         .rd_addr (idx[ch]),
         .rd_data (gdat[ch])
      );
   end

   // registered tint multiply result
   logic [7:0] s7c_ff [3];

   function automatic logic signed [23:0] s5l_in();
      return 24'((s4l_ff + 43'sd32768) >>> 16);
   endfunction

   always_comb v_in = {v_ff[Stages-2:0], in_pop};

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= v_in;
      if (advance) begin
         s1w_ff <= in_item.write;
         s1i_ff <= in_item.index;
         s1val_ff <= in_item.value;
         s1x_ff[0] <= to_frac(in_item.red);
         s1x_ff[1] <= to_frac(in_item.green);
         s1x_ff[2] <= to_frac(in_item.blue);
         s1a_ff <= in_item.alpha;
         tidx_ff[0] <= IdxW'(s1i_ff);
         tval_ff[0] <= s1val_ff;
         for (int k = 1; k < 4; k++) begin
            tidx_ff[k] <= tidx_ff[k-1];
            tval_ff[k] <= tval_ff[k-1];
         end
         for (int c = 0; c < 3; c++) begin
            s2p_ff[c] <= (24'(signed'({1'b0, s1x_ff[c]}))
                          + 24'(signed'(csr.brightness)) * 24'sd16
                          - Half) * signed'({14'd0, csr.contrast});
            s3x_ff[c] <= 24'(((s2p_ff[c] + 26'sd128) >>> 8) + 26'(Half));
            s4x_ff[c] <= s3x_ff[c];
            s5p_ff[c] <= 35'(s4x_ff[c] - s5l_in()) * signed'({25'd0, csr.saturation});
            s7c_ff[c] <= 8'((21'(gdat[c] > 13'(GammaOne) ? 13'(GammaOne) : gdat[c])
                          * 21'(tint[c])) >> 12);
         end
         s2a_ff <= s1a_ff; s3a_ff <= s2a_ff; s4a_ff <= s3a_ff;
         s4l_ff <= 43'(s3x_ff[0]) * 43'sd19595 + 43'(s3x_ff[1]) * 43'sd38470
                   + 43'(s3x_ff[2]) * 43'sd7471;
         s5l_ff <= s5l_in();
         s5a_ff <= s4a_ff; s6a_ff <= s5a_ff; s7a_ff <= s6a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) wpipe_ff <= '0;
      else if (advance) wpipe_ff <= {wpipe_ff[4:0], s1w_ff && v_ff[0]};
   end

   // output fifo, fed from stage 7 on advance
   pixel_type  ofifo_ff [OutDepth];
   logic [2:0] owp_ff, orp_ff;
   logic       opush, opop;
   assign opush = advance && v_ff[Stages-1] && !wpipe_ff[5];
   assign opop  = out_pop && !out_empty;
   assign out_empty = ocnt_ff == '0;
   assign out_pixel = ofifo_ff[orp_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff <= '0; orp_ff <= '0; ocnt_ff <= '0;
      end else begin
         if (opush) owp_ff <= owp_ff + 3'd1;
         if (opop) orp_ff <= orp_ff + 3'd1;
         ocnt_ff <= ocnt_ff + {3'd0, opush} - {3'd0, opop};
      end
      if (opush) ofifo_ff[owp_ff] <= '{red: s7c_ff[0], green: s7c_ff[1],
                                       blue: s7c_ff[2], alpha: s7a_ff};
   end
endmodule
`default_nettype wire

/* rtl/core/pcg_front.sv */
// ----------------------------------------------------------------------------
// pcg_front
// accepts items, classifies them and holds the configuration registers
// ----------------------------------------------------------------------------
`default_nettype none
module pcg_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [9:0]         csr_data,
   output pcg_pkg::csr_type        csr,
   input  wire logic               req_push,
   input  wire logic               req_mode,
   input  wire logic [7:0]         req_red_in,
   input  wire logic [7:0]         req_green_in,
   input  wire logic [7:0]         req_blue_in,
   input  wire logic [7:0]         req_alpha_in,
   input  wire logic [9:0]         req_table_index,
   input  wire logic [12:0]        req_table_value,
   output pcg_pkg::item_type       item,
   output logic                    item_push
);
   import pcg_pkg::*;
   csr_type csr_ff;
   assign csr = csr_ff;
   // table writes beyond the depth are dropped here
   assign item_push = req_push && !(req_mode && (32'(req_table_index) >= TableDepth));
   assign item = '{write: req_mode, red: req_red_in, green: req_green_in,
                   blue: req_blue_in, alpha: req_alpha_in, index: req_table_index,
                   value: req_table_value};
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{brightness: '0, contrast: 10'd256, saturation: 10'd256,
                     tint_red: 8'd255, tint_green: 8'd255, tint_blue: 8'd255};
      end else if (csr_write) begin
         unique case (csr_index)
            CsrBrightness: csr_ff.brightness <= signed'(csr_data);
            CsrContrast:   csr_ff.contrast   <= csr_data;
            CsrSaturation: csr_ff.saturation <= csr_data;
            CsrTintRed:    csr_ff.tint_red   <= csr_data[7:0];
            CsrTintGreen:  csr_ff.tint_green <= csr_data[7:0];
            CsrTintBlue:   csr_ff.tint_blue  <= csr_data[7:0];
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/core/pixel_color_grading_top.sv */
// ----------------------------------------------------------------------------
// pixel_color_grading_top
// rgba8888 color grade: brightness, contrast, saturation, gamma table, tint
// ----------------------------------------------------------------------------
// one pixel per clock sustained while results are popped as they come; each
// graded pixel passes through the decoupling queue, the seven stage back end
// with its registered gamma table read, and the result fifo. mode 1 items load
// one gamma entry and give no result. load the table before grading pixels;
// csr writes only when idle.
`default_nettype none
module pixel_color_grading_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_data,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [7:0]  req_alpha_in,
   input  wire logic [9:0]  req_table_index,
   input  wire logic [12:0] req_table_value,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [7:0]       rsp_alpha_out
);
   import pcg_pkg::*;
   csr_type   csr;
   item_type  f_item, q_item;
   logic      f_push, q_empty, q_pop, q_full;
   pixel_type px;

   // front: registers and classification
   pcg_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .csr,
      .req_push(push && !q_full), .req_mode, .req_red_in, .req_green_in,
      .req_blue_in, .req_alpha_in, .req_table_index, .req_table_value,
      .item(f_item), .item_push(f_push)
   );
   assign full = q_full;

   // decoupling queue
   pcg_queue u_queue (
      .clock, .reset, .push(f_push), .push_data(f_item), .full(q_full),
      .pop(q_pop), .pop_data(q_item), .empty(q_empty)
   );

   // back: grading pipeline and result fifo
   pcg_back u_back (
      .clock, .reset, .csr, .in_valid(!q_empty), .in_item(q_item), .in_pop(q_pop),
      .out_pixel(px), .out_empty(empty), .out_pop(pop)
   );
   assign rsp_red_out   = px.red;
   assign rsp_green_out = px.green;
   assign rsp_blue_out  = px.blue;
   assign rsp_alpha_out = px.alpha;

   // a transfer into the back end needs a waiting entry
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("back end took from an empty queue");
   // queue cannot be full right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !full)
      else $error("queue full after reset");
   // results never appear out of nothing just after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> empty)
      else $error("result waiting after reset");
endmodule
`default_nettype wire
